@@ rtl/core/mcc_pkg.sv @@
// morse codec package: symbol constants, sequencer state type and the
// fixed character-to-code and code-to-character tables
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mcc_pkg;

  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_DASH   = 8'h2D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam int unsigned TABLE_LEN  = 7;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } emit_state_e;

  typedef struct packed {
    logic       vld;
    logic [2:0] len;
    logic [6:0] pat;
  } code_t;

  typedef struct packed {
    logic       spc;
    logic [2:0] cnt;
    logic [6:0] pat;
    logic [7:0] tail;
  } emit_load_t;

  function automatic code_t char_to_code(input logic [6:0] ch);
    code_t c;
    c = '0;
    case (ch)
      7'h21: c = {1'b1, 3'd6, 7'h2B};
      7'h22: c = {1'b1, 3'd6, 7'h12};
      7'h24: c = {1'b1, 3'd7, 7'h09};
      7'h26: c = {1'b1, 3'd5, 7'h08};
      7'h27: c = {1'b1, 3'd6, 7'h1E};
      7'h28: c = {1'b1, 3'd5, 7'h16};
      7'h29: c = {1'b1, 3'd6, 7'h2D};
      7'h2B: c = {1'b1, 3'd5, 7'h0A};
      7'h2C: c = {1'b1, 3'd6, 7'h33};
      7'h2D: c = {1'b1, 3'd6, 7'h21};
      7'h2E: c = {1'b1, 3'd6, 7'h15};
      7'h2F: c = {1'b1, 3'd5, 7'h12};
      7'h30: c = {1'b1, 3'd5, 7'h1F};
      7'h31: c = {1'b1, 3'd5, 7'h0F};
      7'h32: c = {1'b1, 3'd5, 7'h07};
      7'h33: c = {1'b1, 3'd5, 7'h03};
      7'h34: c = {1'b1, 3'd5, 7'h01};
      7'h35: c = {1'b1, 3'd5, 7'h00};
      7'h36: c = {1'b1, 3'd5, 7'h10};
      7'h37: c = {1'b1, 3'd5, 7'h18};
      7'h38: c = {1'b1, 3'd5, 7'h1C};
      7'h39: c = {1'b1, 3'd5, 7'h1E};
      7'h3A: c = {1'b1, 3'd6, 7'h38};
      7'h3B: c = {1'b1, 3'd6, 7'h2A};
      7'h3D: c = {1'b1, 3'd5, 7'h11};
      7'h3F: c = {1'b1, 3'd6, 7'h0C};
      7'h40: c = {1'b1, 3'd6, 7'h1A};
      7'h5F: c = {1'b1, 3'd6, 7'h0D};
      7'h61: c = {1'b1, 3'd2, 7'h01};
      7'h62: c = {1'b1, 3'd4, 7'h08};
      7'h63: c = {1'b1, 3'd4, 7'h0A};
      7'h64: c = {1'b1, 3'd3, 7'h04};
      7'h65: c = {1'b1, 3'd1, 7'h00};
      7'h66: c = {1'b1, 3'd4, 7'h02};
      7'h67: c = {1'b1, 3'd3, 7'h06};
      7'h68: c = {1'b1, 3'd4, 7'h00};
      7'h69: c = {1'b1, 3'd2, 7'h00};
      7'h6A: c = {1'b1, 3'd4, 7'h07};
      7'h6B: c = {1'b1, 3'd3, 7'h05};
      7'h6C: c = {1'b1, 3'd4, 7'h04};
      7'h6D: c = {1'b1, 3'd2, 7'h03};
      7'h6E: c = {1'b1, 3'd2, 7'h02};
      7'h6F: c = {1'b1, 3'd3, 7'h07};
      7'h70: c = {1'b1, 3'd4, 7'h06};
      7'h71: c = {1'b1, 3'd4, 7'h0D};
      7'h72: c = {1'b1, 3'd3, 7'h02};
      7'h73: c = {1'b1, 3'd3, 7'h00};
      7'h74: c = {1'b1, 3'd1, 7'h01};
      7'h75: c = {1'b1, 3'd3, 7'h01};
      7'h76: c = {1'b1, 3'd4, 7'h01};
      7'h77: c = {1'b1, 3'd3, 7'h03};
      7'h78: c = {1'b1, 3'd4, 7'h09};
      7'h79: c = {1'b1, 3'd4, 7'h0B};
      7'h7A: c = {1'b1, 3'd4, 7'h0C};
      default: c = '0;
    endcase
    return c;
  endfunction

  // key is a leading one followed by the pattern, dash as one
  function automatic logic [7:0] code_to_char(input logic [7:0] key);
    logic [7:0] ch;
    ch = 8'h00;
    case (key)
      8'h6B: ch = 8'h21;
      8'h52: ch = 8'h22;
      8'h89: ch = 8'h24;
      8'h28: ch = 8'h26;
      8'h5E: ch = 8'h27;
      8'h36: ch = 8'h28;
      8'h6D: ch = 8'h29;
      8'h2A: ch = 8'h2B;
      8'h73: ch = 8'h2C;
      8'h61: ch = 8'h2D;
      8'h55: ch = 8'h2E;
      8'h32: ch = 8'h2F;
      8'h3F: ch = 8'h30;
      8'h2F: ch = 8'h31;
      8'h27: ch = 8'h32;
      8'h23: ch = 8'h33;
      8'h21: ch = 8'h34;
      8'h20: ch = 8'h35;
      8'h30: ch = 8'h36;
      8'h38: ch = 8'h37;
      8'h3C: ch = 8'h38;
      8'h3E: ch = 8'h39;
      8'h78: ch = 8'h3A;
      8'h6A: ch = 8'h3B;
      8'h31: ch = 8'h3D;
      8'h4C: ch = 8'h3F;
      8'h5A: ch = 8'h40;
      8'h4D: ch = 8'h5F;
      8'h05: ch = 8'h61;
      8'h18: ch = 8'h62;
      8'h1A: ch = 8'h63;
      8'h0C: ch = 8'h64;
      8'h02: ch = 8'h65;
      8'h12: ch = 8'h66;
      8'h0E: ch = 8'h67;
      8'h10: ch = 8'h68;
      8'h04: ch = 8'h69;
      8'h17: ch = 8'h6A;
      8'h0D: ch = 8'h6B;
      8'h14: ch = 8'h6C;
      8'h07: ch = 8'h6D;
      8'h06: ch = 8'h6E;
      8'h0F: ch = 8'h6F;
      8'h16: ch = 8'h70;
      8'h1D: ch = 8'h71;
      8'h0A: ch = 8'h72;
      8'h08: ch = 8'h73;
      8'h03: ch = 8'h74;
      8'h09: ch = 8'h75;
      8'h11: ch = 8'h76;
      8'h0B: ch = 8'h77;
      8'h19: ch = 8'h78;
      8'h1B: ch = 8'h79;
      8'h1C: ch = 8'h7A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mcc_token.sv @@
// decode token accumulator: gathers dots and dashes and looks up the
// closed token in the inverse table
// depends on mcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcc_token
  import mcc_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = 7
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] sym_i,
  input  wire logic       eot_i,
  output logic            hit_o,
  output logic [7:0]      char_o
);

  localparam int unsigned LenW = $clog2(MAX_CODE_LEN + 1);

  logic [MAX_CODE_LEN-1:0] pat_q, pat_d;
  logic [LenW-1:0]         len_q, len_d;
  logic                    pres_q, pres_d;
  logic                    inv_q, inv_d;
  logic                    is_mark, is_space, close, len_ok;
  logic [7:0]              key;

  always_comb begin
    pat_d    = pat_q;
    len_d    = len_q;
    pres_d   = pres_q;
    inv_d    = inv_q;
    is_mark  = (sym_i == CHAR_DOT) || (sym_i == CHAR_DASH);
    is_space = (sym_i == CHAR_SPACE);
    if (is_mark) begin
      pres_d = 1'b1;
      if (len_q >= LenW'(MAX_CODE_LEN)) begin
        inv_d = 1'b1;
      end else begin
        pat_d = {pat_q[MAX_CODE_LEN-2:0], (sym_i == CHAR_DASH)};
        len_d = len_q + LenW'(1);
      end
    end else if (!is_space) begin
      pres_d = 1'b1;
      inv_d  = 1'b1;
    end
    close  = is_space || eot_i;
    len_ok = (len_d != '0) && (len_d <= LenW'(TABLE_LEN));
    key    = (8'd1 << len_d[2:0]) | {1'b0, pat_d[6:0]};
    char_o = code_to_char(key);
    hit_o  = close && pres_d && !inv_d && len_ok && (char_o != 8'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      len_q  <= '0;
      pres_q <= 1'b0;
      inv_q  <= 1'b0;
    end else if (step_i) begin
      if (close) begin
        pat_q  <= '0;
        len_q  <= '0;
        pres_q <= 1'b0;
        inv_q  <= 1'b0;
      end else begin
        pat_q  <= pat_d;
        len_q  <= len_d;
        pres_q <= pres_d;
        inv_q  <= inv_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mcc_emit.sv @@
// symbol sequencer: steps through a loaded code one symbol per transfer,
// then the tail character, into the output register
// depends on mcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcc_emit
  import mcc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire emit_load_t  load_data_i,
  output logic             busy_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       symbol_o,
  output logic             last_o
);

  emit_state_e state_q, state_d;
  logic        spc_q, spc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [6:0]  pat_q, pat_d;
  logic [7:0]  tail_q, tail_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  sym_q, sym_d;
  logic        last_q, last_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    spc_d       = spc_q;
    cnt_d       = cnt_q;
    pat_d       = pat_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q;
    sym_d       = sym_q;
    last_d      = last_q;
    if (out_free) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (load_i) begin
          spc_d   = load_data_i.spc;
          cnt_d   = load_data_i.cnt;
          pat_d   = load_data_i.pat;
          tail_d  = load_data_i.tail;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (cnt_q != 3'd0) begin
            if (spc_q) begin
              sym_d = CHAR_SPACE;
            end else if (pat_q[3'(cnt_q - 3'd1)]) begin
              sym_d = CHAR_DASH;
            end else begin
              sym_d = CHAR_DOT;
            end
            last_d = 1'b0;
            cnt_d  = cnt_q - 3'd1;
          end else begin
            sym_d   = tail_q;
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spc_q  <= spc_d;
    pat_q  <= pat_d;
    tail_q <= tail_d;
    sym_q  <= sym_d;
    last_q <= last_d;
  end

  assign busy_o      = (state_q == ST_RUN);
  assign out_valid_o = out_valid_q;
  assign symbol_o    = sym_q;
  assign last_o      = last_q;

  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> state_q == ST_IDLE)
    else $error("load while sequence running");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> state_q == ST_RUN)
    else $error("load did not start sequence");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> cnt_q == 3'd0)
    else $error("symbols left over in idle");

  a_tail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && out_free && cnt_q == 3'd0) |=>
      (state_q == ST_IDLE && out_valid_q && last_q))
    else $error("tail not marked last");

endmodule

`default_nettype wire

@@ rtl/core/morse_code_codec_top.sv @@
// morse codec top level: direction register, text folding and table
// lookup for encode, token accumulator and symbol sequencer
// depends on mcc_pkg, mcc_token, mcc_emit
//
// usage
// - config: write direction through cfg_valid_i/cfg_ready_o (always ready),
//   0 encodes text to dots and dashes, 1 decodes them to text; write it
//   only while the block is idle
// - input: a byte is taken when in_valid_i is high and in_stall_o is low
// - output: a result is taken when out_valid_o is high and out_stall_i low;
//   last_o marks the final result of an input byte
// - encode: a byte with an L-symbol code gives L+1 results, one per cycle
//   while the output does not stall; the sequencer loads the code and then
//   registers each result; in_stall_o stays high while it runs, stepping
//   one symbol per cycle; a space gives two space results
// - decode: one byte per cycle while the sequencer is idle; a closing byte
//   with a known token loads the sequencer for one result, stalling input
// - a stall on the output holds the sequencer, which then holds the input
// - reset clears the direction to encode, the open token and the output
`timescale 1ns / 1ps
`default_nettype none

module morse_code_codec_top
  import mcc_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = 7
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_direction_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] symbol_in_i,
  input  wire logic       end_of_text_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      symbol_out_o,
  output logic            last_o
);

  logic       dir_q;
  logic       in_xfer, busy;
  logic       tok_hit;
  logic [7:0] tok_char;
  logic [7:0] folded;
  code_t      code;
  logic       load;
  emit_load_t load_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dir_q <= cfg_direction_i;
    end
  end

  assign in_stall_o = busy;
  assign in_xfer    = in_valid_i && !in_stall_o;

  mcc_token #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_token (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(in_xfer && dir_q),
    .sym_i (symbol_in_i),
    .eot_i (end_of_text_i),
    .hit_o (tok_hit),
    .char_o(tok_char)
  );

  always_comb begin
    folded = symbol_in_i;
    if (symbol_in_i >= CHAR_UP_A && symbol_in_i <= CHAR_UP_Z) begin
      folded = symbol_in_i + CASE_OFFSET;
    end
    code      = char_to_code(folded[6:0]);
    load      = 1'b0;
    load_data = '0;
    if (dir_q) begin
      load_data.tail = tok_char;
      load           = in_xfer && tok_hit;
    end else if (symbol_in_i == CHAR_SPACE) begin
      load_data.spc  = 1'b1;
      load_data.cnt  = 3'd1;
      load_data.tail = CHAR_SPACE;
      load           = in_xfer;
    end else begin
      load_data.cnt  = code.len;
      load_data.pat  = code.pat;
      load_data.tail = CHAR_SPACE;
      load           = in_xfer && !folded[7] && code.vld;
    end
  end

  mcc_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .load_data_i(load_data),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .symbol_o   (symbol_out_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire
